// ===== rtl/core/fba_pkg.sv =====
// Shared types and constants for the frame bitmap allocator.
package fba_pkg;

	localparam int FRAME_COUNT_DEF = 4096;
	localparam int WORD_BITS_DEF = 32;
	localparam int LIMIT_W = 13;
	localparam int FIELD_FRAME_W = 12;
	localparam logic [LIMIT_W-1:0] FRAMES_MANAGED_RST = 13'd4096;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE = 1'b1;

	localparam logic [1:0] ST_ALLOCATED = 2'd0;
	localparam logic [1:0] ST_MAPPED = 2'd1;
	localparam logic [1:0] ST_NO_FRAME = 2'd2;
	localparam logic [1:0] ST_FREED = 2'd3;

	typedef struct packed {
		logic kind;
		logic [FIELD_FRAME_W-1:0] cur_frame;
		logic is_kernel;
		logic is_writeable;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [FIELD_FRAME_W-1:0] frame;
		logic present;
		logic rw;
		logic user;
	} rsp_t;

	typedef struct packed {
		logic clear_en;
		logic load;
		logic lookup;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
	} sts_t;

endpackage

// ===== rtl/core/frame_bitmap_allocator.sv =====
// Top level of the first-fit bitmap frame allocator.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   req_t: kind, cur_frame, is_kernel, is_writeable
//   rsp      out        rsp_valid / rsp_stall   rsp_t: status, frame, present, rw, user
//   cfg      in         cfg_we                  cfg_wdata: frames_managed
//
// Each request passes through the transfer in, a lookup that, for an allocation, picks the lowest
// non-full bitmap word from the per-word full flags (for a free it takes the frame's own word) and
// reads it from the RAM, and a commit that finds the free bit (or the bit to clear), writes the
// word back when the request succeeds and loads the result register. After reset a clearing pass
// zeroes the bitmap RAM one word per cycle, all WORD_COUNT words (128 at the default sizes), with req_stall high.
// The result register holds while rsp_stall is high; the next request is taken
// meanwhile and its commit waits until the register is free.
module frame_bitmap_allocator import fba_pkg::*; #(
	parameter int FRAME_COUNT = FRAME_COUNT_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  req_t               req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_t               rsp,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	fba_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req_valid),
		.in_stall(req_stall),
		.out_valid(rsp_valid),
		.out_stall(rsp_stall),
		.cmd(cmd),
		.sts(sts)
	);

	fba_datapath #(
		.FRAME_COUNT(FRAME_COUNT),
		.WORD_BITS(WORD_BITS)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.req(req),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.rsp(rsp)
	);

endmodule

// ===== rtl/core/fba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/fba_ctrl.sv =====
// Controller state machine for the frame bitmap allocator.
module fba_ctrl import fba_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output cmd_t cmd,
	input  sts_t sts
);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE = 2'd1;
	localparam logic [1:0] S_LOOK = 2'd2;
	localparam logic [1:0] S_COMMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (sts.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.lookup = 1'b1;
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = slot_free;
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			out_valid_q <= cmd.commit || (out_valid_q && out_stall);
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// A new result is never written over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten while occupied");

	// After a transfer in, the block stalls its input until the item is done.
	a_stall_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after a transfer");

	// A lookup always follows a load in the next cycle.
	a_load_then_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.lookup)
		else $error("lookup did not follow load");

	// The clearing pass runs only once after reset.
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CLEAR) |=> (state_q != S_CLEAR))
		else $error("clearing pass reentered");

endmodule

// ===== rtl/core/fba_datapath.sv =====
// Datapath for the frame bitmap allocator: bitmap RAM, full flags and result register.
module fba_datapath import fba_pkg::*; #(
	parameter int FRAME_COUNT = FRAME_COUNT_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  req_t               req,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata,
	output rsp_t               rsp
);

	localparam int LB = $clog2(WORD_BITS + 1) - 1;
	localparam int WB = 1 << LB;
	localparam int FW = ($clog2(FRAME_COUNT) > LB) ? $clog2(FRAME_COUNT) : LB + 1;
	localparam int WAW = FW - LB;
	localparam int WORD_COUNT = (FRAME_COUNT + WB - 1) / WB;

	req_t               item_q;
	rsp_t               rsp_q;
	logic [LIMIT_W-1:0] managed_q;
	logic [WAW-1:0]     clr_addr_q;
	logic [WAW-1:0]     addr_q;
	logic               none_q;
	logic [WORD_COUNT-1:0] full_q;

	logic [WAW-1:0] pick_w;
	logic           any_free;
	logic [FW-1:0]  cur_ext;
	logic [WAW-1:0] look_addr;
	logic [WB-1:0]  rdata;
	logic [LB-1:0]  zero_bit;
	logic [LB-1:0]  bit_sel;
	logic [FW-1:0]  alloc_frame;
	logic           is_alloc;
	logic           alloc_ok;
	logic           free_ok;
	logic [WB-1:0]  bit_mask;
	logic [WB-1:0]  new_word;
	logic           mem_we;
	logic           ram_we;
	logic [WAW-1:0] ram_waddr;
	logic [WB-1:0]  ram_wdata;
	rsp_t           rsp_d;

	always_comb begin
		pick_w = '0;
		any_free = 1'b0;
		for (int i = WORD_COUNT - 1; i >= 0; i--) begin
			if (!full_q[i]) begin
				pick_w = WAW'(i);
				any_free = 1'b1;
			end
		end
	end

	assign cur_ext = FW'(item_q.cur_frame);
	assign look_addr = (item_q.kind == KIND_ALLOC) ? pick_w : cur_ext[FW-1:LB];

	always_comb begin
		zero_bit = '0;
		for (int b = WB - 1; b >= 0; b--) begin
			if (!rdata[b]) begin
				zero_bit = LB'(b);
			end
		end
	end

	assign is_alloc = (item_q.kind == KIND_ALLOC) && (item_q.cur_frame == '0);
	assign alloc_frame = {addr_q, zero_bit};
	assign alloc_ok = is_alloc && !none_q
		&& (32'(alloc_frame) < 32'(managed_q))
		&& (32'(alloc_frame) < 32'(FRAME_COUNT));
	assign free_ok = (item_q.kind == KIND_FREE) && (item_q.cur_frame != '0)
		&& (32'(item_q.cur_frame) < 32'(FRAME_COUNT));

	assign bit_sel = is_alloc ? zero_bit : cur_ext[LB-1:0];
	assign bit_mask = WB'(1) << bit_sel;
	assign new_word = is_alloc ? (rdata | bit_mask) : (rdata & ~bit_mask);
	assign mem_we = cmd.commit && (alloc_ok || free_ok);

	assign ram_we = cmd.clear_en || mem_we;
	assign ram_waddr = cmd.clear_en ? clr_addr_q : addr_q;
	assign ram_wdata = cmd.clear_en ? '0 : new_word;

	fba_ram #(
		.WIDTH(WB),
		.DEPTH(WORD_COUNT)
	) u_bitmap (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(cmd.lookup),
		.raddr(look_addr),
		.rdata(rdata)
	);

	assign sts.clear_last = (clr_addr_q == WAW'(WORD_COUNT - 1));

	always_comb begin
		rsp_d = '0;
		if (item_q.kind == KIND_FREE) begin
			rsp_d.status = ST_FREED;
		end else if (!is_alloc) begin
			rsp_d.status = ST_MAPPED;
		end else if (alloc_ok) begin
			rsp_d.status = ST_ALLOCATED;
			rsp_d.frame = FIELD_FRAME_W'(alloc_frame);
			rsp_d.present = 1'b1;
			rsp_d.rw = item_q.is_writeable;
			rsp_d.user = !item_q.is_kernel;
		end else begin
			rsp_d.status = ST_NO_FRAME;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			managed_q <= FRAMES_MANAGED_RST;
			clr_addr_q <= '0;
			full_q <= '0;
		end else begin
			if (cfg_we) begin
				managed_q <= cfg_wdata;
			end
			if (cmd.clear_en) begin
				clr_addr_q <= clr_addr_q + WAW'(1);
			end
			if (mem_we) begin
				full_q[addr_q] <= &new_word;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= req;
		end
		if (cmd.lookup) begin
			addr_q <= look_addr;
			none_q <= !any_free;
		end
		if (cmd.commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== tb/tb_frame_bitmap_allocator.sv =====
// Testbench for the frame bitmap allocator: directed and random transfers, bitmap predictor.
`timescale 1ns / 1ps

module tb_frame_bitmap_allocator;
	import fba_pkg::*;

	class frame_pool_ledger;
		bit [FRAME_COUNT_DEF-1:0] busy;
		logic [LIMIT_W-1:0] limit;
		rsp_t owed[$];
		int errors;

		function new();
			busy = '0;
			limit = FRAMES_MANAGED_RST;
			errors = 0;
		endfunction

		function rsp_t take_request(req_t r);
			rsp_t e;
			int top;
			bit found;
			e = '0;
			found = 1'b0;
			if (r.kind == KIND_FREE) begin
				if (r.cur_frame != 0)
					busy[r.cur_frame] = 1'b0;
				e.status = ST_FREED;
			end else if (r.cur_frame != 0) begin
				e.status = ST_MAPPED;
			end else begin
				top = (limit > FRAME_COUNT_DEF) ? FRAME_COUNT_DEF : int'(limit);
				e.status = ST_NO_FRAME;
				for (int f = 0; f < top; f++) begin
					if (!found && !busy[f]) begin
						found = 1'b1;
						busy[f] = 1'b1;
						e.status = ST_ALLOCATED;
						e.frame = f[FIELD_FRAME_W-1:0];
						e.present = 1'b1;
						e.rw = r.is_writeable;
						e.user = !r.is_kernel;
					end
				end
			end
			owed.push_back(e);
			return e;
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (owed.size() == 0) begin
				$error("unexpected response: status %0d, frame %0d", got.status, got.frame);
				errors++;
				return;
			end
			want = owed.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.frame !== want.frame) begin
				$error("frame: expected %0d, got %0d", want.frame, got.frame);
				errors++;
			end
			if (got.present !== want.present) begin
				$error("present: expected %0d, got %0d", want.present, got.present);
				errors++;
			end
			if (got.rw !== want.rw) begin
				$error("rw: expected %0d, got %0d", want.rw, got.rw);
				errors++;
			end
			if (got.user !== want.user) begin
				$error("user: expected %0d, got %0d", want.user, got.user);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req_bus;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp_bus;
	logic cfg_we;
	logic [LIMIT_W-1:0] cfg_wdata;

	frame_pool_ledger ledger;
	logic [FIELD_FRAME_W-1:0] granted[$];
	bit quiet;
	int hold_req;

	frame_bitmap_allocator uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req_bus),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp_bus),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	function automatic int idle_len();
		int p;
		p = $urandom_range(0, 99);
		if (quiet || p < 60)
			return 0;
		if (p < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic req_t make_req(logic kind, int frame, logic kern, logic wr);
		req_t r;
		r.kind = kind;
		r.cur_frame = frame[FIELD_FRAME_W-1:0];
		r.is_kernel = kern;
		r.is_writeable = wr;
		return r;
	endfunction

	function automatic req_t pick_request(int alloc_pct);
		req_t r;
		int idx;
		r.is_kernel = 1'($urandom_range(0, 1));
		r.is_writeable = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 99) < alloc_pct) begin
			r.kind = KIND_ALLOC;
			r.cur_frame = ($urandom_range(0, 9) < 8) ? '0
				: FIELD_FRAME_W'($urandom_range(1, 4095));
		end else begin
			r.kind = KIND_FREE;
			if (granted.size() > 0 && $urandom_range(0, 3) != 0) begin
				idx = $urandom_range(0, granted.size() - 1);
				r.cur_frame = granted[idx];
				granted.delete(idx);
			end else begin
				r.cur_frame = FIELD_FRAME_W'($urandom_range(0, 4095));
			end
		end
		return r;
	endfunction

	task automatic send_req(input req_t r);
		rsp_t e;
		int n;
		req_bus <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		e = ledger.take_request(r);
		if (e.status == ST_ALLOCATED)
			granted.push_back(e.frame);
		n = idle_len();
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain_all();
		req_valid <= 1'b0;
		while (ledger.owed.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_frames(input logic [LIMIT_W-1:0] v);
		drain_all();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		ledger.limit = v;
	endtask

	task automatic run_phase(input logic [LIMIT_W-1:0] lim, input int count, input int alloc_pct,
			input bit calm, input int hold_at, input int pause_at);
		set_frames(lim);
		quiet = calm;
		for (int i = 0; i < count; i++) begin
			if (i == hold_at)
				hold_req = 400;
			if (i == pause_at)
				drain_all();
			send_req(pick_request(alloc_pct));
		end
	endtask

	initial begin : rsp_side
		int left;
		left = 0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall)
				ledger.check_response(rsp_bus);
			if (hold_req > 0) begin
				left = hold_req;
				hold_req = 0;
			end else if (left == 0) begin
				left = idle_len();
			end
			rsp_stall <= (left > 0);
			if (left > 0)
				left--;
		end
	end

	initial begin
		#4000000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		ledger = new();
		quiet = 1'b0;
		hold_req = 0;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req_bus <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		send_req(make_req(KIND_ALLOC, 0, 1'b0, 1'b0));
		send_req(make_req(KIND_ALLOC, 0, 1'b1, 1'b1));
		send_req(make_req(KIND_ALLOC, 0, 1'b0, 1'b1));
		send_req(make_req(KIND_ALLOC, 0, 1'b1, 1'b0));
		send_req(make_req(KIND_ALLOC, 4095, 1'b0, 1'b1));
		send_req(make_req(KIND_ALLOC, 1, 1'b1, 1'b1));
		send_req(make_req(KIND_FREE, 0, 1'b1, 1'b1));
		send_req(make_req(KIND_ALLOC, 0, 1'b0, 1'b0));
		send_req(make_req(KIND_FREE, 1, 1'b0, 1'b0));
		send_req(make_req(KIND_FREE, 1, 1'b1, 1'b0));
		send_req(make_req(KIND_ALLOC, 0, 1'b1, 1'b1));
		send_req(make_req(KIND_FREE, 4095, 1'b0, 1'b1));
		set_frames(13'd0);
		send_req(make_req(KIND_ALLOC, 0, 1'b0, 1'b1));
		send_req(make_req(KIND_FREE, 2, 1'b1, 1'b0));
		set_frames(13'd3);
		send_req(make_req(KIND_ALLOC, 0, 1'b0, 1'b0));
		send_req(make_req(KIND_ALLOC, 0, 1'b1, 1'b1));
		send_req(make_req(KIND_FREE, 3000, 1'b0, 1'b0));
		send_req(make_req(KIND_FREE, 1, 1'b0, 1'b1));
		send_req(make_req(KIND_ALLOC, 0, 1'b0, 1'b1));
		set_frames(13'd8191);
		send_req(make_req(KIND_ALLOC, 0, 1'b1, 1'b0));
		send_req(make_req(KIND_FREE, 4095, 1'b1, 1'b1));

		run_phase(13'd4096, 450, 75, 1'b0, 200, -1);
		run_phase(LIMIT_W'($urandom_range(2, 60)), 300, 55, 1'b1, -1, -1);
		run_phase(13'd0, 40, 60, 1'b0, -1, -1);
		run_phase(13'd8191, 400, 70, 1'b0, -1, 150);
		run_phase(13'd1, 80, 50, 1'b0, -1, -1);
		run_phase(LIMIT_W'($urandom_range(61, 300)), 500, 65, 1'b0, -1, -1);

		quiet = 1'b1;
		drain_all();
		if (ledger.errors == 0 && ledger.owed.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
